// ===== rtl/ogd_pkg.sv =====
// shared types and constants of the occupancy grid dilation block
`default_nettype none

package ogd_pkg;

   // default grid and kernel limits
   localparam int DEF_MAX_COLS   = 256;
   localparam int DEF_MAX_ROWS   = 256;
   localparam int DEF_MAX_KERNEL = 31;

   // register field widths
   localparam int GRID_W = 9;
   localparam int K_W    = 5;

   // signed cell position width, covers -15 .. 270 plus margin
   localparam int POS_W = 11;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_GRID_COLS   = 2'd0;
   localparam logic [1:0] REG_GRID_ROWS   = 2'd1;
   localparam logic [1:0] REG_KERNEL_SIDE = 2'd2;

   localparam logic [GRID_W-1:0] GRID_COLS_RESET   = 9'd256;
   localparam logic [GRID_W-1:0] GRID_ROWS_RESET   = 9'd256;
   localparam logic [K_W-1:0]    KERNEL_SIDE_RESET = 5'd0;

   // request commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // effective configuration, already saturated to the build limits
   typedef struct packed {
      logic [GRID_W-1:0] cols;
      logic [GRID_W-1:0] rows;
      logic [K_W-1:0]    k;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/ogd_csr.sv =====
// configuration registers with apb-style access and saturation to the build limits
`default_nettype none

module ogd_csr
   import ogd_pkg::*;
#(
   parameter int MAX_COLS   = DEF_MAX_COLS,
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic [GRID_W-1:0] grid_cols_ff, grid_cols_in;
   logic [GRID_W-1:0] grid_rows_ff, grid_rows_in;
   logic [K_W-1:0]    kernel_side_ff, kernel_side_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      grid_cols_in   = grid_cols_ff;
      grid_rows_in   = grid_rows_ff;
      kernel_side_in = kernel_side_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GRID_COLS:   grid_cols_in   = csr_pwdata[GRID_W-1:0];
            REG_GRID_ROWS:   grid_rows_in   = csr_pwdata[GRID_W-1:0];
            REG_KERNEL_SIDE: kernel_side_in = csr_pwdata[K_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff   <= GRID_COLS_RESET;
         grid_rows_ff   <= GRID_ROWS_RESET;
         kernel_side_ff <= KERNEL_SIDE_RESET;
      end else begin
         grid_cols_ff   <= grid_cols_in;
         grid_rows_ff   <= grid_rows_in;
         kernel_side_ff <= kernel_side_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRID_COLS:   csr_prdata = CSR_DATA_W'(grid_cols_ff);
         REG_GRID_ROWS:   csr_prdata = CSR_DATA_W'(grid_rows_ff);
         REG_KERNEL_SIDE: csr_prdata = CSR_DATA_W'(kernel_side_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // saturate to the build limits
   always_comb begin
      cfg.cols = (32'(grid_cols_ff) > MAX_COLS) ? GRID_W'(MAX_COLS) : grid_cols_ff;
      cfg.rows = (32'(grid_rows_ff) > MAX_ROWS) ? GRID_W'(MAX_ROWS) : grid_rows_ff;
      cfg.k    = (32'(kernel_side_ff) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : kernel_side_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/occupancy_grid_dilation.sv =====
// top level of the occupancy grid dilation block: cell memory, window scan, result strobe
`default_nettype none

// Binary occupancy grid with square dilation. A write request (cmd 0) stores one
// cell's bit; writes outside MAX_COLS x MAX_ROWS are dropped. A query request
// (cmd 1) returns one result: a query outside the grid in use, or any query with
// kernel_side 0, answers in the cycle after acceptance and keeps busy low. Any
// other query scans the K x K window one cell per cycle through the single read
// port of the cell memory, passing through the scan and then the drain state;
// busy rises once the query is accepted and drops in the cycle that carries the
// result. The result is on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall it, so it must take it then. After reset
// a clearing pass zeroes all 2**(clog2(MAX_COLS) + clog2(MAX_ROWS)) entries of
// the cell memory (65536 by default) one entry per cycle, with busy high;
// configuration writes are taken during that pass as at any time.
// Configuration should only be written while the block is idle.

module occupancy_grid_dilation
   import ogd_pkg::*;
#(
   parameter int MAX_COLS   = DEF_MAX_COLS,
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_cmd,
   input  wire logic [7:0]            req_col,
   input  wire logic [7:0]            req_row,
   input  wire logic                  req_cell_value,
   // result channel
   output logic                       rsp_valid,
   output logic                       rsp_dilated,
   output logic                       rsp_out_of_range,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // memory address is {row, col}
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 2 ** AW;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   cfg_type cfg;

   ogd_csr #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // control and datapath registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [K_W-1:0]    i_ff, i_in;
   logic [K_W-1:0]    j_ff, j_in;
   logic [POS_W-1:0]  base_r_ff, base_r_in;
   logic [POS_W-1:0]  base_c_ff, base_c_in;
   logic              hit_ff, hit_in;
   logic              vld_d_ff, vld_d_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_dil_ff, rsp_dil_in;
   logic              rsp_oor_ff, rsp_oor_in;
   logic              rd_data_ff;

   // cell memory, one bit per cell
   logic              cell_mem [DEPTH];
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic              mem_wdata;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   logic              accept;
   logic              req_oor;
   logic              wr_inside;
   logic [31:0]       row_x, col_x;
   logic [AW-1:0]     wr_addr;
   logic [K_W-1:0]    k_half, k_hi, k_m1;
   logic [POS_W-1:0]  pr, pc;
   logic [31:0]       pr_x, pc_x;
   logic              in_bounds;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   // query cell against the grid in use
   assign req_oor = ({1'b0, req_col} >= cfg.cols) || ({1'b0, req_row} >= cfg.rows);

   // write address, dropped when beyond the build limits
   assign row_x     = 32'(req_row);
   assign col_x     = 32'(req_col);
   assign wr_inside = (row_x < MAX_ROWS) && (col_x < MAX_COLS);
   assign wr_addr   = {row_x[RW-1:0], col_x[CW-1:0]};

   // window offsets run from -h to k-1-h, sources at q - offset
   assign k_half = cfg.k >> 1;
   assign k_hi   = cfg.k - 5'd1 - k_half;
   assign k_m1   = cfg.k - 5'd1;

   // current source cell, top bit set means negative
   assign pr = base_r_ff + POS_W'(i_ff);
   assign pc = base_c_ff + POS_W'(j_ff);
   assign pr_x = 32'(pr);
   assign pc_x = 32'(pc);
   assign in_bounds = !pr[POS_W-1] && !pc[POS_W-1]
                      && (pr < POS_W'(cfg.rows)) && (pc < POS_W'(cfg.cols));
   assign rd_addr = {pr_x[RW-1:0], pc_x[CW-1:0]};

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      base_r_in    = base_r_ff;
      base_c_in    = base_c_ff;
      hit_in       = hit_ff;
      vld_d_in     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_dil_in   = rsp_dil_ff;
      rsp_oor_in   = rsp_oor_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // zero one entry per cycle after reset
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_WRITE) begin
                  mem_we    = wr_inside;
                  mem_waddr = wr_addr;
                  mem_wdata = req_cell_value;
               end else if (req_oor) begin
                  rsp_valid_in = 1'b1;
                  rsp_dil_in   = 1'b0;
                  rsp_oor_in   = 1'b1;
               end else if (cfg.k == '0) begin
                  // disabled kernel, everything free
                  rsp_valid_in = 1'b1;
                  rsp_dil_in   = 1'b0;
                  rsp_oor_in   = 1'b0;
               end else begin
                  base_r_in = POS_W'(req_row) - POS_W'(k_hi);
                  base_c_in = POS_W'(req_col) - POS_W'(k_hi);
                  i_in      = '0;
                  j_in      = '0;
                  hit_in    = 1'b0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, fold in the read of the cycle before
            rd_en    = 1'b1;
            vld_d_in = in_bounds;
            hit_in   = hit_ff | (vld_d_ff & rd_data_ff);
            if (j_ff == k_m1) begin
               j_in = '0;
               if (i_ff == k_m1) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last read lands here
            rsp_valid_in = 1'b1;
            rsp_dil_in   = hit_ff | (vld_d_ff & rd_data_ff);
            rsp_oor_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         vld_d_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         vld_d_ff     <= vld_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      base_r_ff  <= base_r_in;
      base_c_ff  <= base_c_in;
      hit_ff     <= hit_in;
      rsp_dil_ff <= rsp_dil_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dilated      = rsp_dil_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // a write request never produces a result
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_WRITE) |=> !rsp_valid)
      else $error("result strobe after a write request");

   // the end of a scan always gives one in-range result
   a_drain_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (rsp_valid && !rsp_out_of_range))
      else $error("scan ended without an in-range result");

   // out of range results are never marked dilated
   a_oor_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> !rsp_dilated)
      else $error("out of range result marked dilated");

   // no result while memory clearing runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !rsp_valid)
      else $error("result strobe during clearing pass");

endmodule

`default_nettype wire

// ===== dv/tb_occupancy_grid_dilation.sv =====
// testbench for the occupancy grid dilation block: random and directed cell requests, self-checked
`timescale 1ns / 1ps

module tb_occupancy_grid_dilation;
   import ogd_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS   = 600;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 1000;    // outlasts the longest window scan
   // longest quiet stretch of a correct run is the clearing pass of the cell memory after reset
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int MAX_PRINTED    = 100;

   // register index with nothing behind it
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic       cmd;
      logic [7:0] col;
      logic [7:0] row;
      logic       value;
   } grid_request_type;

   typedef struct packed {
      logic dilated;
      logic out_of_range;
   } grid_answer_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_cmd = CMD_WRITE;
   logic [7:0]            req_col = '0;
   logic [7:0]            req_row = '0;
   logic                  req_cell_value = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_dilated;
   logic                  rsp_out_of_range;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   occupancy_grid_dilation dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_dilated      (rsp_dilated),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // shadow of the block: register copies and the cell memory, cleared at reset
   // ---------------------------------------------------------------------------
   logic [GRID_W-1:0] shadow_cols   = GRID_COLS_RESET;
   logic [GRID_W-1:0] shadow_rows   = GRID_ROWS_RESET;
   logic [K_W-1:0]    shadow_kernel = KERNEL_SIDE_RESET;
   bit                shadow_cells [DEF_MAX_COLS*DEF_MAX_ROWS];

   grid_request_type pending_requests [$];
   grid_answer_type  expected_answers [$];
   grid_request_type current_request = '0;

   int  mismatch_count = 0;
   int  random_issued  = 0;
   int  quiet_cycles   = 0;
   int  gap_left       = 0;
   bit  in_flight      = 1'b0;
   bit  request_taken  = 1'b0;
   bit  hold_for_drain = 1'b0;
   bit  no_gaps        = 1'b0;
   bit  drain_mode     = 1'b0;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) begin
         $display("%0t ns mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // dilated value of one cell under the current shadow settings
   function automatic grid_answer_type dilate_cell(input logic [7:0] col, input logic [7:0] row);
      int              cols;
      int              rows;
      int              k;
      int              h;
      int              pc;
      int              pr;
      grid_answer_type ans;
      // sizes above the build limits saturate
      cols = (shadow_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(shadow_cols);
      rows = (shadow_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(shadow_rows);
      k    = (shadow_kernel > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : int'(shadow_kernel);
      h    = k / 2;
      ans  = '0;
      // outside the grid in use: no scan, flagged, never dilated
      if (int'(col) >= cols || int'(row) >= rows) begin
         ans.out_of_range = 1'b1;
         return ans;
      end
      // window offsets run -h .. k-1-h; sources off the grid take no part, nothing wraps
      for (int dr = -h; dr <= k - 1 - h; dr++) begin
         for (int dc = -h; dc <= k - 1 - h; dc++) begin
            pr = int'(row) - dr;
            pc = int'(col) - dc;
            if (pr >= 0 && pr < rows && pc >= 0 && pc < cols &&
                shadow_cells[pr * DEF_MAX_COLS + pc]) begin
               ans.dilated = 1'b1;
            end
         end
      end
      return ans;
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: takes items from the pending queue, drives at the falling edge
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         // the monitor saw the last request go in: draw the gap before the next one
         if (request_taken) begin
            request_taken  = 1'b0;
            in_flight      = 1'b0;
            gap_left       = no_gaps ? 0 : $urandom_range(0, 19);
            hold_for_drain = drain_mode && ($urandom_range(0, 3) == 0);
         end
         if (!in_flight) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0 &&
                         !(hold_for_drain && expected_answers.size() != 0)) begin
               current_request = pending_requests.pop_front();
               in_flight       = 1'b1;
               hold_for_drain  = 1'b0;
            end
         end
         // one assignment per signal per edge; idle cycles carry junk on the fields
         start          <= in_flight;
         req_cmd        <= in_flight ? current_request.cmd   : 1'($urandom);
         req_col        <= in_flight ? current_request.col   : 8'($urandom);
         req_row        <= in_flight ? current_request.row   : 8'($urandom);
         req_cell_value <= in_flight ? current_request.value : 1'($urandom);
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: checks results, predicts accepted requests, watches for a hang
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      grid_answer_type want;
      bit              progress;
      if (!reset) begin
         progress = 1'b0;
         // result first: a request accepted at this edge cannot own it
         if (rsp_valid) begin
            progress = 1'b1;
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("result with none expected, dilated %0b out_of_range %0b",
                                         rsp_dilated, rsp_out_of_range));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_dilated !== want.dilated) begin
                  report_mismatch($sformatf("dilated %0b, expected %0b",
                                            rsp_dilated, want.dilated));
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                            rsp_out_of_range, want.out_of_range));
               end
            end
         end
         if (start && !busy) begin
            progress      = 1'b1;
            request_taken = 1'b1;
            if (current_request.cmd == CMD_WRITE) begin
               // writes land anywhere in the full memory, inside the grid in use or not
               shadow_cells[int'(current_request.row) * DEF_MAX_COLS +
                            int'(current_request.col)] = current_request.value;
            end else begin
               expected_answers.push_back(dilate_cell(current_request.col, current_request.row));
            end
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("occupancy_grid_dilation test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------
   task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                               input logic [CSR_DATA_W-1:0] data,
                               output logic [CSR_DATA_W-1:0] rdata);
      // setup cycle, then access cycle until pready
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write one register, mirror it, and read it back unless it is unmapped
   task automatic set_register(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] want;
      apb_transfer(1'b1, idx, data, readback);
      case (idx)
         REG_GRID_COLS:   shadow_cols   = data[GRID_W-1:0];
         REG_GRID_ROWS:   shadow_rows   = data[GRID_W-1:0];
         REG_KERNEL_SIDE: shadow_kernel = data[K_W-1:0];
         default: ;
      endcase
      if (idx != REG_UNMAPPED) begin
         apb_transfer(1'b0, idx, '0, readback);
         want = (idx == REG_GRID_COLS) ? CSR_DATA_W'(shadow_cols) :
                (idx == REG_GRID_ROWS) ? CSR_DATA_W'(shadow_rows) : CSR_DATA_W'(shadow_kernel);
         if (readback !== want) begin
            report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      idx, readback, want));
         end
      end
   endtask

   // block idle: nothing queued, nothing in flight, no result owed, busy low
   task automatic wait_until_idle();
      do @(posedge clock);
      while (pending_requests.size() != 0 || in_flight || expected_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   // new grid and kernel; upper bits of the write data carry junk the block must drop
   task automatic apply_settings(input logic [GRID_W-1:0] cols, input logic [GRID_W-1:0] rows,
                                 input logic [K_W-1:0] k);
      logic [CSR_DATA_W-1:0] junk;
      wait_until_idle();
      junk = $urandom;
      set_register(REG_GRID_COLS, {junk[CSR_DATA_W-1:GRID_W], cols});
      junk = $urandom;
      set_register(REG_GRID_ROWS, {junk[CSR_DATA_W-1:GRID_W], rows});
      junk = $urandom;
      set_register(REG_KERNEL_SIDE, {junk[CSR_DATA_W-1:K_W], k});
   endtask

   task automatic queue_request(input logic cmd, input logic [7:0] col, input logic [7:0] row,
                                input logic value);
      grid_request_type item;
      item.cmd   = cmd;
      item.col   = col;
      item.row   = row;
      item.value = value;
      pending_requests.push_back(item);
   endtask

   // mostly small grids, now and then empty, full or oversized
   function automatic logic [GRID_W-1:0] draw_grid_size();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return GRID_W'(DEF_MAX_COLS);
         2:       return GRID_W'($urandom_range(257, 511));
         3:       return GRID_W'($urandom_range(41, 255));
         default: return GRID_W'($urandom_range(1, 40));
      endcase
   endfunction

   // the scan reads every cell of the K x K window, so the widest windows stay rare
   function automatic logic [K_W-1:0] draw_kernel();
      case ($urandom_range(0, 11))
         0:       return K_W'(DEF_MAX_KERNEL);
         1:       return K_W'($urandom_range(8, 30));
         default: return K_W'($urandom_range(0, 7));
      endcase
   endfunction

   // a small window of cells per axis so writes and queries meet, reaching past the grid edge
   task automatic pick_window(input logic [GRID_W-1:0] size, output int origin, output int span);
      int eff;
      eff = (size > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(size);
      if (eff <= 48) begin
         origin = 0;
         span   = eff + 3;
      end else begin
         origin = ($urandom_range(0, 2) == 0) ? eff - 16 : $urandom_range(0, eff - 16);
         span   = 19;
      end
   endtask

   function automatic logic [7:0] draw_coord(input int origin, input int span);
      int c;
      c = origin + $urandom_range(0, span);
      return (c > 255) ? 8'd255 : 8'(c);
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   initial begin
      logic [GRID_W-1:0] cols;
      logic [GRID_W-1:0] rows;
      logic [K_W-1:0]    k;
      int                origin_c;
      int                span_c;
      int                origin_r;
      int                span_r;
      int                count;
      bit                first_phase;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // let the clearing pass of the cell memory finish
      repeat (2) @(negedge clock);
      while (busy) @(negedge clock);

      // reset settings, kernel 0: nothing dilates, corners written
      queue_request(CMD_WRITE, 8'd0,   8'd0,   1'b1);
      queue_request(CMD_WRITE, 8'd255, 8'd255, 1'b1);
      queue_request(CMD_QUERY, 8'd0,   8'd0,   1'b1);
      queue_request(CMD_QUERY, 8'd255, 8'd255, 1'b0);

      // single-cell window, then a cleared cell
      apply_settings(9'd256, 9'd256, 5'd1);
      queue_request(CMD_QUERY, 8'd0,   8'd0,   1'b0);
      queue_request(CMD_QUERY, 8'd1,   8'd0,   1'b0);
      queue_request(CMD_QUERY, 8'd255, 8'd255, 1'b1);
      queue_request(CMD_WRITE, 8'd0,   8'd0,   1'b0);
      queue_request(CMD_QUERY, 8'd0,   8'd0,   1'b0);

      // even side: window is lopsided, -1 .. 0
      apply_settings(9'd256, 9'd256, 5'd2);
      queue_request(CMD_QUERY, 8'd254, 8'd254, 1'b0);
      queue_request(CMD_QUERY, 8'd0,   8'd0,   1'b0);

      // widest window at the far corner and away from it
      apply_settings(9'd256, 9'd256, 5'd31);
      queue_request(CMD_QUERY, 8'd240, 8'd240, 1'b0);
      queue_request(CMD_QUERY, 8'd0,   8'd128, 1'b0);
      queue_request(CMD_QUERY, 8'd255, 8'd0,   1'b1);

      // oversized column count with zero rows: every query out of range, writes still land
      apply_settings(9'd511, 9'd0, 5'd31);
      queue_request(CMD_QUERY, 8'd5,   8'd5,   1'b0);
      queue_request(CMD_WRITE, 8'd200, 8'd3,   1'b1);

      apply_settings(9'd0, 9'd300, 5'd4);
      queue_request(CMD_QUERY, 8'd0,   8'd0,   1'b0);

      // a cell written outside a small grid stays dark until the grid grows over it
      apply_settings(9'd10, 9'd10, 5'd3);
      set_register(REG_UNMAPPED, $urandom);
      queue_request(CMD_WRITE, 8'd12,  8'd5,   1'b1);
      queue_request(CMD_QUERY, 8'd9,   8'd5,   1'b0);
      queue_request(CMD_QUERY, 8'd10,  8'd5,   1'b0);
      apply_settings(9'd20, 9'd10, 5'd3);
      queue_request(CMD_QUERY, 8'd11,  8'd5,   1'b0);
      queue_request(CMD_QUERY, 8'd19,  8'd9,   1'b0);

      // random phases: fresh settings each, clustered writes and queries, some junk cells
      first_phase = 1'b1;
      while (random_issued < RANDOM_ITEMS) begin
         cols = draw_grid_size();
         rows = draw_grid_size();
         k    = draw_kernel();
         apply_settings(cols, rows, k);
         no_gaps     = ($urandom_range(0, 4) == 0);
         // at least one phase makes the sender now and then wait for every owed result
         drain_mode  = first_phase || ($urandom_range(0, 4) == 0);
         first_phase = 1'b0;
         pick_window(cols, origin_c, span_c);
         pick_window(rows, origin_r, span_r);
         count = $urandom_range(16, 40);
         repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               queue_request(1'($urandom_range(0, 1)), draw_coord(origin_c, span_c),
                             draw_coord(origin_r, span_r), $urandom_range(0, 4) < 3);
            end
         end
         random_issued += count;
      end

      wait_until_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("occupancy_grid_dilation test passed");
      end else begin
         $display("occupancy_grid_dilation test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ogd_pkg.sv
rtl/ogd_csr.sv
rtl/occupancy_grid_dilation.sv
dv/tb_occupancy_grid_dilation.sv
